/* design/estm_pkg.sv */
// Shared types, constants and arithmetic helpers for the Euler scale/translate matrix block.
// Used by every module of the block; depends on nothing else.
package estm_pkg;

  localparam int ANGLE_W  = 16;
  localparam int SCALE_W  = 24;
  localparam int ENTRY_W  = 32;
  localparam int SC_W     = 32;
  localparam int PROD_W   = 64;
  localparam int COEF_W   = 33;
  localparam int FPROD_W  = ENTRY_W + COEF_W;
  localparam int QUO_W    = 31;
  localparam int CORDIC_W = 34;
  localparam int DIV_LAT  = QUO_W + 2;
  localparam int MERGE_LAT = 5;
  localparam int ATAN_LEN = 24;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;
  localparam logic signed [PROD_W-1:0] HALF_Q30 = 64'sd536870912;

  localparam logic OP_MODEL  = 1'b0;
  localparam logic OP_NORMAL = 1'b1;

  localparam logic [1:0] COL_LAST_NORMAL = 2'd2;
  localparam logic [1:0] COL_TRANS       = 2'd3;

  typedef struct packed {
    logic                        operation;
    logic signed [ANGLE_W-1:0]   angle_x;
    logic signed [ANGLE_W-1:0]   angle_y;
    logic signed [ANGLE_W-1:0]   angle_z;
    logic signed [SCALE_W-1:0]   scale_x;
    logic signed [SCALE_W-1:0]   scale_y;
    logic signed [SCALE_W-1:0]   scale_z;
    logic signed [ENTRY_W-1:0]   shift_x;
    logic signed [ENTRY_W-1:0]   shift_y;
    logic signed [ENTRY_W-1:0]   shift_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  column_index;
    logic signed [ENTRY_W-1:0]   entry_row0;
    logic signed [ENTRY_W-1:0]   entry_row1;
    logic signed [ENTRY_W-1:0]   entry_row2;
    logic signed [ENTRY_W-1:0]   entry_row3;
    logic                        last_column;
    logic                        zero_scale;
  } out_item_t;

  typedef struct packed {
    logic                        op;
    logic signed [ENTRY_W-1:0]   shift_x;
    logic signed [ENTRY_W-1:0]   shift_y;
    logic signed [ENTRY_W-1:0]   shift_z;
  } side_t;

  function automatic logic [31:0] atan_turn(input int unsigned idx);
    case (idx)
      0:  return 32'd536870912;
      1:  return 32'd316933406;
      2:  return 32'd167458907;
      3:  return 32'd85004756;
      4:  return 32'd42667331;
      5:  return 32'd21354465;
      6:  return 32'd10679838;
      7:  return 32'd5340245;
      8:  return 32'd2670163;
      9:  return 32'd1335087;
      10: return 32'd667544;
      11: return 32'd333772;
      12: return 32'd166886;
      13: return 32'd83443;
      14: return 32'd41722;
      15: return 32'd20861;
      16: return 32'd10430;
      17: return 32'd5215;
      18: return 32'd2608;
      19: return 32'd1304;
      20: return 32'd652;
      21: return 32'd326;
      22: return 32'd163;
      23: return 32'd81;
      default: return 32'd0;
    endcase
  endfunction

  // Rounds a Q60 product to Q30.
  function automatic logic signed [SC_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + HALF_Q30;
    return SC_W'(s >>> 30);
  endfunction

  // Rounds a factor times coefficient product to an entry and saturates it.
  function automatic logic signed [ENTRY_W-1:0] round_sat(input logic signed [FPROD_W-1:0] p);
    logic signed [FPROD_W-1:0] s;
    logic signed [FPROD_W-31:0] q;
    logic signed [FPROD_W-31:0] qmax;
    s = p + FPROD_W'(HALF_Q30);
    q = (FPROD_W-30)'(s >>> 30);
    qmax = (FPROD_W-30)'(32'h7fff_ffff);
    if (q > qmax) begin
      return ENTRY_W'(qmax);
    end else if (q < ~qmax) begin
      return ENTRY_W'(~qmax);
    end
    return ENTRY_W'(q);
  endfunction

endpackage

/* design/euler_scale_translate_matrix_top.sv */
// Top level of the Euler (Y-X-Z) scale/translate matrix generator.
// Depends on estm_pkg, estm_cordic_lane, estm_recip_lane and estm_merge.
// An item passes through the CORDIC and divider lanes and then the coefficient merge
// before its columns reach the output register, and each item then occupies the
// result port for four columns (model matrix) or three columns (normal matrix),
// one column per transfer; that port sets the sustained rate.
// The pipeline keeps accepting items while columns drain and halts only when a
// finished item waits for the output register.
module euler_scale_translate_matrix_top import estm_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int TOTAL = DIV_LAT + MERGE_LAT;

  logic                      adv, load, can_load, vld_last, out_xfer, last_col;
  logic                      vld_r [TOTAL];
  side_t                     side_r [TOTAL];

  logic signed [ANGLE_W-1:0] angle_c [3];
  logic signed [SCALE_W-1:0] scale_c [3];
  logic signed [SC_W-1:0]    sin_c [3];
  logic signed [SC_W-1:0]    cos_c [3];
  logic signed [ENTRY_W-1:0] factor_c [3];
  logic                      zero_c [3];
  logic signed [FPROD_W-1:0] prod_c [9];
  logic                      mzero_c [3];

  logic                      busy_r, busy_nxt;
  logic [1:0]                col_r, col_nxt;
  side_t                     hold_r;
  logic signed [ENTRY_W-1:0] ent_r [3][3];
  logic                      zr_r [3];

  assign angle_c[0] = in_data.angle_x;
  assign angle_c[1] = in_data.angle_y;
  assign angle_c[2] = in_data.angle_z;
  assign scale_c[0] = in_data.scale_x;
  assign scale_c[1] = in_data.scale_y;
  assign scale_c[2] = in_data.scale_z;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    estm_cordic_lane #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clk   (clk),
      .en    (adv),
      .angle (angle_c[l]),
      .sin_o (sin_c[l]),
      .cos_o (cos_c[l])
    );
    estm_recip_lane #(.FRAC_BITS(FRACTION_BITS)) u_recip (
      .clk    (clk),
      .en     (adv),
      .op     (in_data.operation),
      .scale  (scale_c[l]),
      .factor (factor_c[l]),
      .zero   (zero_c[l])
    );
  end

  estm_merge u_merge (
    .clk      (clk),
    .en       (adv),
    .sin_i    (sin_c),
    .cos_i    (cos_c),
    .factor_i (factor_c),
    .zero_i   (zero_c),
    .prod_o   (prod_c),
    .zero_o   (mzero_c)
  );

  assign vld_last = vld_r[TOTAL-1];
  assign out_xfer = busy_r && !out_stall;
  assign last_col = (col_r == COL_TRANS) || (hold_r.op == OP_NORMAL && col_r == COL_LAST_NORMAL);
  assign can_load = !busy_r || (out_xfer && last_col);
  assign load     = vld_last && can_load;
  assign adv      = !vld_last || can_load;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOTAL; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TOTAL; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].op      <= in_data.operation;
      side_r[0].shift_x <= in_data.shift_x;
      side_r[0].shift_y <= in_data.shift_y;
      side_r[0].shift_z <= in_data.shift_z;
      for (int i = 1; i < TOTAL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    col_nxt  = col_r;
    if (out_xfer) begin
      if (last_col) begin
        busy_nxt = 1'b0;
      end else begin
        col_nxt = col_r + 2'd1;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= side_r[TOTAL-1];
      zr_r   <= mzero_c;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          ent_r[c][r] <= round_sat(prod_c[c*3+r]);
        end
      end
    end
  end

  assign out_valid = busy_r;

  always_comb begin
    out_data              = '0;
    out_data.column_index = col_r;
    out_data.last_column  = last_col;
    if (col_r == COL_TRANS) begin
      out_data.entry_row0 = hold_r.shift_x;
      out_data.entry_row1 = hold_r.shift_y;
      out_data.entry_row2 = hold_r.shift_z;
      out_data.entry_row3 = ENTRY_W'(1) << FRACTION_BITS;
    end else begin
      out_data.entry_row0 = ent_r[col_r][0];
      out_data.entry_row1 = ent_r[col_r][1];
      out_data.entry_row2 = ent_r[col_r][2];
      out_data.zero_scale = zr_r[col_r];
    end
  end

  a_trans_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.column_index == COL_TRANS |-> out_data.last_column)
    else $error("translation column not marked last");

  a_zero_only_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_scale |-> hold_r.op == OP_NORMAL && out_data.entry_row3 == '0)
    else $error("zero scale flag outside a normal matrix column");

  a_column_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !last_col |=> out_valid && col_r == $past(col_r) + 2'd1)
    else $error("column sequence broken");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    vld_last && !adv |=> vld_last)
    else $error("finished item lost while waiting for the output register");

  a_new_matrix_starts: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid && col_r == '0)
    else $error("loaded matrix does not start at column zero");

endmodule

/* design/estm_cordic_lane.sv */
// One sine/cosine lane: a pipelined CORDIC rotator with one stage per iteration.
// Depends on estm_pkg; output is padded with registers so the lane lines up with the reciprocal lane.
module estm_cordic_lane import estm_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic signed [SC_W-1:0]    sin_o,
  output logic signed [SC_W-1:0]    cos_o
);

  localparam int PAD = DIV_LAT - 1 - STEPS;

  logic [31:0]                 a_c;
  logic                        flip_c;
  logic signed [CORDIC_W-1:0]  z0_c;

  logic signed [CORDIC_W-1:0]  x_r [STEPS];
  logic signed [CORDIC_W-1:0]  y_r [STEPS];
  logic signed [CORDIC_W-1:0]  z_r [STEPS];
  logic                        flip_r [STEPS];

  logic signed [SC_W-1:0]      sin_r [PAD+1];
  logic signed [SC_W-1:0]      cos_r [PAD+1];

  assign a_c    = {angle, 16'h0000};
  assign flip_c = a_c[31] ^ a_c[30];
  assign z0_c   = {{(CORDIC_W-31){a_c[31] ^ flip_c}}, a_c[30:0]};

  for (genvar k = 0; k < STEPS; k++) begin : g_iter
    logic signed [CORDIC_W-1:0] xi, yi, zi;
    logic                       fi;
    logic signed [CORDIC_W-1:0] at;
    if (k == 0) begin : g_first
      assign xi = CORDIC_W'(GAIN_Q30);
      assign yi = '0;
      assign zi = z0_c;
      assign fi = flip_c;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
      assign fi = flip_r[k-1];
    end
    assign at = CORDIC_W'(atan_turn(k));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CORDIC_W-1]) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - at;
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + at;
        end
        flip_r[k] <= fi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flip_r[STEPS-1]) begin
        cos_r[0] <= SC_W'(-x_r[STEPS-1]);
        sin_r[0] <= SC_W'(-y_r[STEPS-1]);
      end else begin
        cos_r[0] <= SC_W'(x_r[STEPS-1]);
        sin_r[0] <= SC_W'(y_r[STEPS-1]);
      end
      for (int i = 1; i <= PAD; i++) begin
        cos_r[i] <= cos_r[i-1];
        sin_r[i] <= sin_r[i-1];
      end
    end
  end

  assign sin_o = sin_r[PAD];
  assign cos_o = cos_r[PAD];

endmodule

/* design/estm_recip_lane.sv */
// One column factor lane: passes the scale in model mode, or forms its rounded
// reciprocal with a pipelined restoring divider in normal mode. Depends on estm_pkg.
module estm_recip_lane import estm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      op,
  input  logic signed [SCALE_W-1:0] scale,
  output logic signed [ENTRY_W-1:0] factor,
  output logic                      zero
);

  localparam int NUM_W = 2 * FRAC_BITS + 2;
  localparam int RW    = (NUM_W > SCALE_W + QUO_W) ? NUM_W : SCALE_W + QUO_W;

  typedef struct packed {
    logic                op;
    logic                neg;
    logic                zero;
    logic                sat;
    logic [SCALE_W-1:0]  scale;
    logic [SCALE_W-1:0]  mag;
    logic [RW-1:0]       rem;
    logic [QUO_W-1:0]    quo;
  } div_stage_t;

  div_stage_t          st_r [QUO_W+1];
  logic [SCALE_W-1:0]  mag_c;
  logic [RW-1:0]       num_c;
  logic [QUO_W-1:0]    qmag_c;
  logic [ENTRY_W-1:0]  qext_c;

  assign mag_c  = scale[SCALE_W-1] ? SCALE_W'(-scale) : SCALE_W'(scale);
  assign num_c  = (RW'(1) << (2 * FRAC_BITS)) + RW'(mag_c >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].op    <= op;
      st_r[0].neg   <= scale[SCALE_W-1];
      st_r[0].zero  <= (scale == '0);
      st_r[0].sat   <= (num_c >= (RW'(mag_c) << QUO_W));
      st_r[0].scale <= scale;
      st_r[0].mag   <= mag_c;
      st_r[0].rem   <= num_c;
      st_r[0].quo   <= '0;
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_div
    localparam int K = QUO_W - j;
    logic [RW-1:0] dv;
    div_stage_t    nx;
    assign dv = RW'(st_r[j-1].mag) << K;
    always_comb begin
      nx = st_r[j-1];
      if (st_r[j-1].rem >= dv) begin
        nx.rem   = st_r[j-1].rem - dv;
        nx.quo[K] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= nx;
      end
    end
  end

  assign qmag_c = st_r[QUO_W].sat ? '1 : st_r[QUO_W].quo;
  assign qext_c = {1'b0, qmag_c};

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= (st_r[QUO_W].op == OP_NORMAL) && st_r[QUO_W].zero;
      if (st_r[QUO_W].op == OP_MODEL) begin
        factor <= ENTRY_W'($signed(st_r[QUO_W].scale));
      end else if (st_r[QUO_W].zero) begin
        factor <= {1'b0, {QUO_W{1'b1}}};
      end else if (st_r[QUO_W].neg) begin
        factor <= -qext_c;
      end else begin
        factor <= qext_c;
      end
    end
  end

endmodule

/* design/estm_merge.sv */
// Merging stage: combines the lane sines and cosines into the nine rotation
// coefficients and multiplies each by its column factor. Depends on estm_pkg.
module estm_merge import estm_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [SC_W-1:0]    sin_i [3],
  input  logic signed [SC_W-1:0]    cos_i [3],
  input  logic signed [ENTRY_W-1:0] factor_i [3],
  input  logic                      zero_i [3],
  output logic signed [FPROD_W-1:0] prod_o [9],
  output logic                      zero_o [3]
);

  localparam int D_C1C3 = 0;
  localparam int D_C2S3 = 1;
  localparam int D_C3S1 = 2;
  localparam int D_C1S3 = 3;
  localparam int D_C2C3 = 4;
  localparam int D_S1S3 = 5;
  localparam int D_C2S1 = 6;
  localparam int D_C1C2 = 7;

  logic signed [SC_W-1:0]    s1, c1, s2, c2, s3, c3;

  logic signed [PROD_W-1:0]  pt_r, pu_r;
  logic signed [PROD_W-1:0]  p_r [8];
  logic signed [SC_W-1:0]    s2_1_r, s3_1_r, c3_1_r;
  logic signed [ENTRY_W-1:0] f_1_r [3];
  logic                      z_1_r [3];

  logic signed [SC_W-1:0]    t_r, u_r;
  logic signed [SC_W-1:0]    d_2_r [8];
  logic signed [SC_W-1:0]    s2_2_r, s3_2_r, c3_2_r;
  logic signed [ENTRY_W-1:0] f_2_r [3];
  logic                      z_2_r [3];

  logic signed [PROD_W-1:0]  pts_r, pus_r, ptc_r, puc_r;
  logic signed [SC_W-1:0]    d_3_r [8];
  logic signed [SC_W-1:0]    s2_3_r;
  logic signed [ENTRY_W-1:0] f_3_r [3];
  logic                      z_3_r [3];

  logic signed [COEF_W-1:0]  coef_r [9];
  logic signed [ENTRY_W-1:0] f_4_r [3];
  logic                      z_4_r [3];

  logic signed [FPROD_W-1:0] prod_r [9];
  logic                      z_5_r [3];

  assign s1 = sin_i[1];
  assign c1 = cos_i[1];
  assign s2 = sin_i[0];
  assign c2 = cos_i[0];
  assign s3 = sin_i[2];
  assign c3 = cos_i[2];

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r          <= s1 * s2;
      pu_r          <= c1 * s2;
      p_r[D_C1C3]   <= c1 * c3;
      p_r[D_C2S3]   <= c2 * s3;
      p_r[D_C3S1]   <= c3 * s1;
      p_r[D_C1S3]   <= c1 * s3;
      p_r[D_C2C3]   <= c2 * c3;
      p_r[D_S1S3]   <= s1 * s3;
      p_r[D_C2S1]   <= c2 * s1;
      p_r[D_C1C2]   <= c1 * c2;
      s2_1_r        <= s2;
      s3_1_r        <= s3;
      c3_1_r        <= c3;
      f_1_r         <= factor_i;
      z_1_r         <= zero_i;

      t_r <= rnd30(pt_r);
      u_r <= rnd30(pu_r);
      for (int i = 0; i < 8; i++) begin
        d_2_r[i] <= rnd30(p_r[i]);
      end
      s2_2_r <= s2_1_r;
      s3_2_r <= s3_1_r;
      c3_2_r <= c3_1_r;
      f_2_r  <= f_1_r;
      z_2_r  <= z_1_r;

      pts_r  <= t_r * s3_2_r;
      pus_r  <= u_r * s3_2_r;
      ptc_r  <= t_r * c3_2_r;
      puc_r  <= u_r * c3_2_r;
      d_3_r  <= d_2_r;
      s2_3_r <= s2_2_r;
      f_3_r  <= f_2_r;
      z_3_r  <= z_2_r;

      coef_r[0] <= COEF_W'(d_3_r[D_C1C3]) + COEF_W'(rnd30(pts_r));
      coef_r[1] <= COEF_W'(d_3_r[D_C2S3]);
      coef_r[2] <= COEF_W'(rnd30(pus_r)) - COEF_W'(d_3_r[D_C3S1]);
      coef_r[3] <= COEF_W'(rnd30(ptc_r)) - COEF_W'(d_3_r[D_C1S3]);
      coef_r[4] <= COEF_W'(d_3_r[D_C2C3]);
      coef_r[5] <= COEF_W'(rnd30(puc_r)) + COEF_W'(d_3_r[D_S1S3]);
      coef_r[6] <= COEF_W'(d_3_r[D_C2S1]);
      coef_r[7] <= -COEF_W'(s2_3_r);
      coef_r[8] <= COEF_W'(d_3_r[D_C1C2]);
      f_4_r     <= f_3_r;
      z_4_r     <= z_3_r;

      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod_r[c*3+r] <= f_4_r[c] * coef_r[c*3+r];
        end
      end
      z_5_r <= z_4_r;
    end
  end

  assign prod_o = prod_r;
  assign zero_o = z_5_r;

endmodule
